[rtl/assert_macros.svh]
// assertion macros for the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sct_pkg.sv]
// shared constants and types for the taylor sine/cosine pipeline
`timescale 1ns / 1ps
package sct_pkg;

  localparam int TERMS   = 12;
  localparam int NTERMS  = 2 * TERMS;
  localparam int N_CELLS = NTERMS - 1;

  localparam int ANGLE_W    = 32;
  localparam int OUT_W      = 32;
  localparam int FRAC_SHIFT = 16;
  localparam int Q_FRAC     = 40;
  localparam int OUT_SHIFT  = 10;

  localparam int X_W   = 49;
  localparam int R_W   = 43;
  localparam int T_W   = 47;
  localparam int P_W   = 50;
  localparam int ACC_W = 52;
  localparam int MUL_W = T_W + R_W;

  localparam int T_LO_W = 24;
  localparam int T_HI_W = T_W - T_LO_W;
  localparam int R_LO_W = 21;
  localparam int R_HI_W = R_W - R_LO_W;

  localparam int NUM_W    = $clog2(NTERMS);
  localparam int CHUNK_W  = P_W / 2;
  localparam int DIV_BASE = CHUNK_W + NUM_W;
  localparam int SHIFT_W  = $clog2(DIV_BASE + NUM_W + 1);
  localparam int RECIP_W  = DIV_BASE + 2;
  localparam int X2_W     = CHUNK_W + NUM_W;
  localparam int PROD1_W  = CHUNK_W + RECIP_W;
  localparam int PROD2_W  = X2_W + RECIP_W;

  localparam int MOD_STEPS = 6;
  localparam logic [R_W-1:0] TWO_PI_Q40 = 43'h6487ED5110B;
  localparam logic [X_W-1:0] MOD_OFFSET = X_W'(TWO_PI_Q40) * X_W'(21);

  typedef struct packed {
    logic [NUM_W-1:0]   n;
    logic [SHIFT_W-1:0] shift;
    logic [RECIP_W-1:0] recip;
  } div_const_t;

  typedef struct packed {
    logic [T_W-1:0]          term;
    logic [R_W-1:0]          r;
    logic signed [ACC_W-1:0] sine;
    logic signed [ACC_W-1:0] cosine;
  } term_bus_t;

endpackage

[rtl/sct_mod_cell.sv]
// one conditional-subtract step of the angle reduction chain
`timescale 1ns / 1ps
module sct_mod_cell import sct_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic [X_W-1:0] modulus,
  input  logic           valid_in,
  input  logic [X_W-1:0] x_in,
  output logic           valid_out,
  output logic [X_W-1:0] x_out
);

  logic [X_W:0] diff;

  assign diff = {1'b0, x_in} - {1'b0, modulus};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= diff[X_W] ? x_in : diff[X_W-1:0];
    end
  end

endmodule

[rtl/sct_term_cell.sv]
// one series term: multiply by the angle, divide by n, accumulate
`timescale 1ns / 1ps
module sct_term_cell import sct_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  div_const_t dc,
  input  logic       valid_in,
  input  term_bus_t  bus_in,
  output logic       valid_out,
  output term_bus_t  bus_out
);

  logic [5:1] v;

  // stage 1: partial products
  logic [T_HI_W+R_HI_W-1:0] pp_hh;
  logic [T_HI_W+R_LO_W-1:0] pp_hl;
  logic [T_LO_W+R_HI_W-1:0] pp_lh;
  logic [T_LO_W+R_LO_W-1:0] pp_ll;
  logic [R_W-1:0]           r1;
  logic signed [ACC_W-1:0]  sin1, cos1;

  // stage 2: rounded product
  logic [MUL_W-1:0]         mul_sum;
  logic [P_W-1:0]           p2;
  logic [R_W-1:0]           r2;
  logic signed [ACC_W-1:0]  sin2, cos2;

  // stage 3: high chunk times reciprocal
  logic [PROD1_W-1:0]       prod1;
  logic [CHUNK_W-1:0]       x1_3, plo3;
  logic [R_W-1:0]           r3;
  logic signed [ACC_W-1:0]  sin3, cos3;

  // stage 4: high quotient and remainder
  logic [CHUNK_W-1:0]       q1;
  logic [CHUNK_W-1:0]       rem_full;
  logic [CHUNK_W-1:0]       q1_4, plo4;
  logic [NUM_W-1:0]         rem4;
  logic [R_W-1:0]           r4;
  logic signed [ACC_W-1:0]  sin4, cos4;

  // stage 5: low chunk times reciprocal
  logic [PROD2_W-1:0]       prod2;
  logic [CHUNK_W-1:0]       q1_5;
  logic [R_W-1:0]           r5;
  logic signed [ACC_W-1:0]  sin5, cos5;

  // stage 6: new term and sums
  logic [CHUNK_W-1:0]       q2;
  logic [T_W-1:0]           term_next;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  sine_next, cosine_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      valid_out <= 1'b0;
    end else if (en) begin
      v         <= {v[4:1], valid_in};
      valid_out <= v[5];
    end
  end

  assign mul_sum = (MUL_W'(pp_hh) << (T_LO_W + R_LO_W))
                 + (MUL_W'(pp_hl) << T_LO_W)
                 + (MUL_W'(pp_lh) << R_LO_W)
                 + MUL_W'(pp_ll)
                 + (MUL_W'(1) << (Q_FRAC - 1));

  assign q1       = CHUNK_W'(prod1 >> dc.shift);
  assign rem_full = x1_3 - CHUNK_W'(q1 * CHUNK_W'(dc.n));

  always_comb begin
    q2          = CHUNK_W'(prod2 >> dc.shift);
    term_next   = T_W'({q1_5, q2});
    addend      = $signed({{(ACC_W - T_W){1'b0}}, term_next});
    sine_next   = sin5;
    cosine_next = cos5;
    if (dc.n[1]) begin
      addend = -addend;
    end
    if (dc.n[0]) begin
      sine_next = sin5 + addend;
    end else begin
      cosine_next = cos5 + addend;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh <= (T_HI_W+R_HI_W)'(bus_in.term[T_W-1:T_LO_W])
             * (T_HI_W+R_HI_W)'(bus_in.r[R_W-1:R_LO_W]);
      pp_hl <= (T_HI_W+R_LO_W)'(bus_in.term[T_W-1:T_LO_W])
             * (T_HI_W+R_LO_W)'(bus_in.r[R_LO_W-1:0]);
      pp_lh <= (T_LO_W+R_HI_W)'(bus_in.term[T_LO_W-1:0])
             * (T_LO_W+R_HI_W)'(bus_in.r[R_W-1:R_LO_W]);
      pp_ll <= (T_LO_W+R_LO_W)'(bus_in.term[T_LO_W-1:0])
             * (T_LO_W+R_LO_W)'(bus_in.r[R_LO_W-1:0]);
      r1    <= bus_in.r;
      sin1  <= bus_in.sine;
      cos1  <= bus_in.cosine;

      p2    <= mul_sum[Q_FRAC +: P_W];
      r2    <= r1;
      sin2  <= sin1;
      cos2  <= cos1;

      prod1 <= PROD1_W'(p2[P_W-1 -: CHUNK_W]) * PROD1_W'(dc.recip);
      x1_3  <= p2[P_W-1 -: CHUNK_W];
      plo3  <= p2[CHUNK_W-1:0];
      r3    <= r2;
      sin3  <= sin2;
      cos3  <= cos2;

      q1_4  <= q1;
      rem4  <= NUM_W'(rem_full);
      plo4  <= plo3;
      r4    <= r3;
      sin4  <= sin3;
      cos4  <= cos3;

      prod2 <= PROD2_W'({rem4, plo4}) * PROD2_W'(dc.recip);
      q1_5  <= q1_4;
      r5    <= r4;
      sin5  <= sin4;
      cos5  <= cos4;

      bus_out.term   <= term_next;
      bus_out.r      <= r5;
      bus_out.sine   <= sine_next;
      bus_out.cosine <= cosine_next;
    end
  end

endmodule

[rtl/sine_cosine_taylor.sv]
// top level: angle reduction, taylor term chain, rounding and output buffer
//
//   channel   signals          contents (lowest bits first)
//   in        s_axis_t*        angle, signed q7.24 radians
//   out       m_axis_t*        sine_value, cosine_value, signed q2.30
//
// one angle per cycle while the output buffer is not full; stages in order into the
// output buffer: 1 entry stage, 6 reduction cells, 6 stages per term cell, 1 rounding stage
// the whole pipeline advances together; it holds while the two-entry output
// buffer is full, so s_axis_tready does not depend on m_axis_tready
// reset clears the valid bits and the buffer; data registers are not reset
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sine_cosine_taylor import sct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [ANGLE_W-1:0]   s_axis_tdata,   // angle
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [2*OUT_W-1:0]   m_axis_tdata    // sine_value, cosine_value
);

  localparam logic [1:0] BUF_FULL = 2'd2;
  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (OUT_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX  = (ACC_W'(1) << (OUT_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_MIN  = ~SAT_MAX;

  function automatic logic [OUT_W-1:0] to_q30(input logic signed [ACC_W-1:0] s);
    logic signed [ACC_W-1:0] rnd;
    rnd = (s + HALF_LSB) >>> OUT_SHIFT;
    if (rnd > SAT_MAX) begin
      return OUT_W'(SAT_MAX);
    end else if (rnd < SAT_MIN) begin
      return OUT_W'(SAT_MIN);
    end
    return OUT_W'(rnd);
  endfunction

  logic                    en;
  logic signed [X_W-1:0]   wide;
  logic                    valid_m [MOD_STEPS+1];
  logic [X_W-1:0]          x_m     [MOD_STEPS+1];
  logic                    valid_t [N_CELLS+1];
  term_bus_t               bus_t   [N_CELLS+1];

  logic                    v_out;
  logic [OUT_W-1:0]        sin_q, cos_q;

  logic [2*OUT_W-1:0]      buf_data [2];
  logic                    wr_ptr, rd_ptr;
  logic [1:0]              count, count_next;
  logic                    push, pop;

  assign en            = (count != BUF_FULL);
  assign s_axis_tready = en;
  assign wide          = X_W'($signed(s_axis_tdata)) <<< FRAC_SHIFT;

  // entry: widen to q40 and add a multiple of 2*pi so the value is positive
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_m[0] <= 1'b0;
    end else if (en) begin
      valid_m[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_m[0] <= wide + MOD_OFFSET;
    end
  end

  for (genvar k = 0; k < MOD_STEPS; k++) begin : g_mod
    sct_mod_cell u_mod (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .modulus   (X_W'(TWO_PI_Q40) << (MOD_STEPS - 1 - k)),
      .valid_in  (valid_m[k]),
      .x_in      (x_m[k]),
      .valid_out (valid_m[k+1]),
      .x_out     (x_m[k+1])
    );
  end

  assign valid_t[0]        = valid_m[MOD_STEPS];
  assign bus_t[0].term     = T_W'(1) << Q_FRAC;
  assign bus_t[0].r        = x_m[MOD_STEPS][R_W-1:0];
  assign bus_t[0].sine     = '0;
  assign bus_t[0].cosine   = ACC_W'(1) << Q_FRAC;

  for (genvar i = 0; i < N_CELLS; i++) begin : g_term
    localparam int unsigned N = i + 1;
    localparam int unsigned S = DIV_BASE + $clog2(N);
    localparam logic [63:0] M = ((64'd1 << S) + 64'(N) - 64'd1) / 64'(N);
    div_const_t dc;

    assign dc.n     = NUM_W'(N);
    assign dc.shift = SHIFT_W'(S);
    assign dc.recip = RECIP_W'(M);

    sct_term_cell u_term (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .dc        (dc),
      .valid_in  (valid_t[i]),
      .bus_in    (bus_t[i]),
      .valid_out (valid_t[i+1]),
      .bus_out   (bus_t[i+1])
    );
  end

  // rounding to q2.30 with saturation
  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= valid_t[N_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q <= to_q30(bus_t[N_CELLS].sine);
      cos_q <= to_q30(bus_t[N_CELLS].cosine);
    end
  end

  // two-entry output buffer
  assign push          = en & v_out;
  assign pop           = m_axis_tvalid & m_axis_tready;
  assign m_axis_tvalid = (count != 2'd0);
  assign m_axis_tdata  = buf_data[rd_ptr];
  assign count_next    = count + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_data[wr_ptr] <= {cos_q, sin_q};
    end
  end

  `ASSERT_IMPLIES(a_no_push_full, clk, rst, push, count != BUF_FULL, "push into full buffer")
  `ASSERT_NEXT(a_count_track, clk, rst, 1'b1, count == $past(count) + 2'($past(push)) - 2'($past(pop)), "buffer count mismatch")
  `ASSERT_NEXT(a_stall_hold, clk, rst, !en && v_out, v_out && $stable(sin_q) && $stable(cos_q), "result lost during stall")

endmodule
